>>> rtl/gbn_pkg.sv
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared types and constants of the go-back-n sender window: operation,
// frame kind and status codes, configuration register map and command queue.
// ----------------------------------------------------------------------------
package gbn_pkg;

  typedef enum logic [1:0] {
    OP_ENQUEUE = 2'd0,
    OP_SEND    = 2'd1,
    OP_ACK     = 2'd2,
    OP_TICK    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_NEW    = 2'd0,
    KIND_RESEND = 2'd1,
    KIND_STATUS = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_STALE = 2'd1,
    STAT_RANGE = 2'd2,
    STAT_FULL  = 2'd3
  } status_e;

  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 16;
  localparam int WIN_CFG_BITS  = 4;
  localparam int TMO_CFG_BITS  = 16;

  localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_SIZE   = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TIMEOUT_TICKS = 1'b1;

  localparam logic [WIN_CFG_BITS-1:0] WIN_RESET = 4'd8;
  localparam logic [TMO_CFG_BITS-1:0] TMO_RESET = 16'd1000;

  localparam int CMDQ_DEPTH = 2;

  typedef struct packed {
    logic valid;
    op_e  op;
  } cmd_ctrl_t;

endpackage

>>> rtl/gbn_ram.sv
// ----------------------------------------------------------------------------
// gbn_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module gbn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/gbn_front.sv
// ----------------------------------------------------------------------------
// gbn_front
// Command front end: accepts transactions, decodes the operation and holds
// them in a short queue until the execution unit takes them.
// ----------------------------------------------------------------------------
module gbn_front #(
  parameter int PAYLOAD_BITS = 32,
  parameter int SEQ_BITS     = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [1:0]                operation_i,
  input  logic [PAYLOAD_BITS-1:0]   payload_i,
  input  logic [SEQ_BITS-1:0]       ack_number_i,
  output logic                      busy_o,
  output gbn_pkg::cmd_ctrl_t        cmd_o,
  output logic [PAYLOAD_BITS-1:0]   cmd_payload_o,
  output logic [SEQ_BITS-1:0]       cmd_ack_o,
  input  logic                      pop_i
);
  import gbn_pkg::*;

  localparam int QAW = CMDQ_DEPTH > 1 ? $clog2(CMDQ_DEPTH) : 1;
  localparam int QCW = $clog2(CMDQ_DEPTH + 1);

  op_e                     op_q  [CMDQ_DEPTH];
  logic [PAYLOAD_BITS-1:0] pay_q [CMDQ_DEPTH];
  logic [SEQ_BITS-1:0]     ack_q [CMDQ_DEPTH];
  logic [QAW-1:0]          wptr_q, wptr_d, rptr_q, rptr_d;
  logic [QCW-1:0]          cnt_q, cnt_d;
  logic                    full, accept, pop;

  assign full   = (cnt_q == QCW'(CMDQ_DEPTH));
  assign accept = start_i && !full;
  assign pop    = pop_i && (cnt_q != '0);
  assign busy_o = full;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (accept) begin
      wptr_d = (wptr_q == QAW'(CMDQ_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop) begin
      rptr_d = (rptr_q == QAW'(CMDQ_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (accept && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !accept) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // operation decode
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q[wptr_q]  <= op_e'(operation_i);
      pay_q[wptr_q] <= payload_i;
      ack_q[wptr_q] <= ack_number_i;
    end
  end

  assign cmd_o.valid   = (cnt_q != '0);
  assign cmd_o.op      = op_q[rptr_q];
  assign cmd_payload_o = pay_q[rptr_q];
  assign cmd_ack_o     = ack_q[rptr_q];

endmodule

>>> rtl/gbn_back.sv
// ----------------------------------------------------------------------------
// gbn_back
// Execution unit: pending payload queue, sliding window store, sequence
// numbers, retransmit timer and result register.
// ----------------------------------------------------------------------------
module gbn_back #(
  parameter int MAX_WINDOW    = 8,
  parameter int SEQ_BITS      = 8,
  parameter int PENDING_DEPTH = 16,
  parameter int PAYLOAD_BITS  = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  gbn_pkg::cmd_ctrl_t                cmd_i,
  input  logic [PAYLOAD_BITS-1:0]           cmd_payload_i,
  input  logic [SEQ_BITS-1:0]               cmd_ack_i,
  output logic                              pop_o,
  input  logic [gbn_pkg::WIN_CFG_BITS-1:0]  window_size_i,
  input  logic [gbn_pkg::TMO_CFG_BITS-1:0]  timeout_ticks_i,
  output logic                              result_valid_o,
  output logic [1:0]                        kind_o,
  output logic [SEQ_BITS-1:0]               seq_number_o,
  output logic [PAYLOAD_BITS-1:0]           frame_payload_o,
  output logic                              last_o,
  output logic [1:0]                        status_o,
  output logic                              finished_o
);
  import gbn_pkg::*;

  localparam int SLOT_AW = MAX_WINDOW > 1 ? $clog2(MAX_WINDOW) : 1;
  localparam int PEND_AW = $clog2(PENDING_DEPTH);
  localparam int PCNT_W  = $clog2(PENDING_DEPTH + 1);
  localparam int WCNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int CW_A    = SEQ_BITS > PCNT_W ? SEQ_BITS : PCNT_W;
  localparam int CW_B    = WCNT_W > WIN_CFG_BITS ? WCNT_W : WIN_CFG_BITS;
  localparam int CW      = CW_A > CW_B ? CW_A : CW_B;
  localparam int SEQ_MAX = (2 ** SEQ_BITS) - 1;
  localparam int WIN_LIM = MAX_WINDOW < SEQ_MAX ? MAX_WINDOW : SEQ_MAX;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEND   = 2'd1;
  localparam logic [1:0] S_RESEND = 2'd2;

  function automatic logic [SLOT_AW-1:0] wrap_slot(input logic [SLOT_AW:0] s);
    logic [SLOT_AW:0] r;
    r = (s >= (SLOT_AW+1)'(MAX_WINDOW)) ? s - (SLOT_AW+1)'(MAX_WINDOW) : s;
    return r[SLOT_AW-1:0];
  endfunction

  logic [1:0]              state_q, state_d;
  logic [SEQ_BITS-1:0]     base_q, base_d, next_q, next_d, em_seq_q, em_seq_d;
  logic [SLOT_AW-1:0]      bslot_q, bslot_d, rslot_q, rslot_d;
  logic [PEND_AW-1:0]      head_q, head_d, tail_q, tail_d;
  logic [PCNT_W-1:0]       pcnt_q, pcnt_d;
  logic [TMO_CFG_BITS-1:0] timer_q, timer_d;
  logic [WCNT_W-1:0]       rd_left_q, rd_left_d, em_left_q, em_left_d;
  logic                    rd_pend_q, rd_pend_d;

  logic                    out_valid_q, out_valid_d;
  kind_e                   kind_q, kind_d;
  logic [SEQ_BITS-1:0]     seq_q, seq_d;
  logic [PAYLOAD_BITS-1:0] pay_q, pay_d;
  logic                    last_q, last_d;
  status_e                 status_q, status_d;
  logic                    finished_q, finished_d;

  logic                    p_we, p_re, w_we, w_re;
  logic [PAYLOAD_BITS-1:0] p_rdata, w_rdata;
  logic [SLOT_AW-1:0]      wr_slot, ack_slot, rs_next;

  logic [SEQ_BITS-1:0]     outs, d;
  logic [CW-1:0]           out_c, pc_c, win_c, room, mv_c;
  logic                    ack_ok, ack_fin, fin_now, expire, pfull;
  logic [TMO_CFG_BITS-1:0] t1, lim;
  logic [PEND_AW-1:0]      head_inc, tail_inc;

  gbn_ram #(.WIDTH(PAYLOAD_BITS), .DEPTH(PENDING_DEPTH)) u_pending (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (tail_q),
    .wdata_i (cmd_payload_i),
    .re_i    (p_re),
    .raddr_i (head_q),
    .rdata_o (p_rdata)
  );

  gbn_ram #(.WIDTH(PAYLOAD_BITS), .DEPTH(MAX_WINDOW)) u_window (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (wr_slot),
    .wdata_i (p_rdata),
    .re_i    (w_re),
    .raddr_i (rslot_q),
    .rdata_o (w_rdata)
  );

  assign outs    = next_q - base_q;
  assign out_c   = CW'(outs);
  assign pc_c    = CW'(pcnt_q);
  assign win_c   = (window_size_i == '0) ? CW'(1) :
                   ((CW'(window_size_i) > CW'(WIN_LIM)) ? CW'(WIN_LIM) : CW'(window_size_i));
  assign room    = win_c - out_c;
  assign mv_c    = (out_c < win_c) ? ((pc_c < room) ? pc_c : room) : '0;
  assign fin_now = (pcnt_q == '0) && (outs == '0);
  assign pfull   = (pcnt_q == PCNT_W'(PENDING_DEPTH));

  // cumulative ack classification
  assign d       = cmd_ack_i - base_q;
  assign ack_ok  = CW'(d) < out_c;
  assign ack_fin = (pcnt_q == '0) && ((CW'(d) + CW'(1)) == out_c);

  assign t1      = timer_q + 1'b1;
  assign lim     = (timeout_ticks_i == '0) ? TMO_CFG_BITS'(1) : timeout_ticks_i;
  assign expire  = (t1 >= lim);

  assign head_inc = (head_q == PEND_AW'(PENDING_DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign tail_inc = (tail_q == PEND_AW'(PENDING_DEPTH - 1)) ? '0 : tail_q + 1'b1;
  assign wr_slot  = wrap_slot((SLOT_AW+1)'(bslot_q) + (SLOT_AW+1)'(outs));
  assign ack_slot = wrap_slot((SLOT_AW+1)'(bslot_q) + (SLOT_AW+1)'(d) + (SLOT_AW+1)'(1));
  assign rs_next  = wrap_slot((SLOT_AW+1)'(rslot_q) + (SLOT_AW+1)'(1));

  always_comb begin
    state_d     = state_q;
    base_d      = base_q;
    next_d      = next_q;
    em_seq_d    = em_seq_q;
    bslot_d     = bslot_q;
    rslot_d     = rslot_q;
    head_d      = head_q;
    tail_d      = tail_q;
    pcnt_d      = pcnt_q;
    timer_d     = timer_q;
    rd_left_d   = rd_left_q;
    em_left_d   = em_left_q;
    rd_pend_d   = 1'b0;
    out_valid_d = 1'b0;
    kind_d      = kind_q;
    seq_d       = seq_q;
    pay_d       = pay_q;
    last_d      = last_q;
    status_d    = status_q;
    finished_d  = finished_q;
    p_we        = 1'b0;
    p_re        = 1'b0;
    w_we        = 1'b0;
    w_re        = 1'b0;
    pop_o       = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_i.valid) begin
          pop_o       = 1'b1;
          out_valid_d = 1'b1;
          kind_d      = KIND_STATUS;
          seq_d       = '0;
          pay_d       = '0;
          last_d      = 1'b1;
          status_d    = STAT_OK;
          finished_d  = fin_now;
          unique case (cmd_i.op)
            OP_ENQUEUE: begin
              finished_d = 1'b0;
              if (pfull) begin
                status_d = STAT_FULL;
              end else begin
                p_we   = 1'b1;
                tail_d = tail_inc;
                pcnt_d = pcnt_q + 1'b1;
              end
            end
            OP_SEND: begin
              if (mv_c != '0) begin
                out_valid_d = 1'b0;
                state_d     = S_SEND;
                rd_left_d   = WCNT_W'(mv_c);
                em_left_d   = WCNT_W'(mv_c);
              end
            end
            OP_ACK: begin
              if (ack_ok) begin
                base_d     = cmd_ack_i + 1'b1;
                bslot_d    = ack_slot;
                finished_d = ack_fin;
              end else if (d[SEQ_BITS-1]) begin
                status_d = STAT_STALE;
              end else begin
                status_d = STAT_RANGE;
              end
            end
            OP_TICK: begin
              if (expire) begin
                timer_d = '0;
                if (outs != '0) begin
                  out_valid_d = 1'b0;
                  state_d     = S_RESEND;
                  rd_left_d   = WCNT_W'(out_c);
                  em_left_d   = WCNT_W'(out_c);
                  rslot_d     = bslot_q;
                  em_seq_d    = base_q;
                end
              end else begin
                timer_d = t1;
              end
            end
            default: begin
              status_d = STAT_OK;
            end
          endcase
        end
      end

      S_SEND: begin
        if (rd_left_q != '0) begin
          p_re      = 1'b1;
          head_d    = head_inc;
          pcnt_d    = pcnt_q - 1'b1;
          rd_left_d = rd_left_q - 1'b1;
          rd_pend_d = 1'b1;
        end
        if (rd_pend_q) begin
          w_we        = 1'b1;
          out_valid_d = 1'b1;
          kind_d      = KIND_NEW;
          seq_d       = next_q;
          pay_d       = p_rdata;
          last_d      = (em_left_q == WCNT_W'(1));
          status_d    = STAT_OK;
          finished_d  = 1'b0;
          next_d      = next_q + 1'b1;
          em_left_d   = em_left_q - 1'b1;
          if (em_left_q == WCNT_W'(1)) begin
            state_d = S_IDLE;
          end
        end
      end

      S_RESEND: begin
        if (rd_left_q != '0) begin
          w_re      = 1'b1;
          rslot_d   = rs_next;
          rd_left_d = rd_left_q - 1'b1;
          rd_pend_d = 1'b1;
        end
        if (rd_pend_q) begin
          out_valid_d = 1'b1;
          kind_d      = KIND_RESEND;
          seq_d       = em_seq_q;
          pay_d       = w_rdata;
          last_d      = (em_left_q == WCNT_W'(1));
          status_d    = STAT_OK;
          finished_d  = 1'b0;
          em_seq_d    = em_seq_q + 1'b1;
          em_left_d   = em_left_q - 1'b1;
          if (em_left_q == WCNT_W'(1)) begin
            state_d = S_IDLE;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      base_q      <= '0;
      next_q      <= '0;
      bslot_q     <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      pcnt_q      <= '0;
      timer_q     <= '0;
      rd_left_q   <= '0;
      em_left_q   <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      base_q      <= base_d;
      next_q      <= next_d;
      bslot_q     <= bslot_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      pcnt_q      <= pcnt_d;
      timer_q     <= timer_d;
      rd_left_q   <= rd_left_d;
      em_left_q   <= em_left_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rslot_q    <= rslot_d;
    em_seq_q   <= em_seq_d;
    kind_q     <= kind_d;
    seq_q      <= seq_d;
    pay_q      <= pay_d;
    last_q     <= last_d;
    status_q   <= status_d;
    finished_q <= finished_d;
  end

  assign result_valid_o  = out_valid_q;
  assign kind_o          = kind_q;
  assign seq_number_o    = seq_q;
  assign frame_payload_o = pay_q;
  assign last_o          = last_q;
  assign status_o        = status_q;
  assign finished_o      = finished_q;

endmodule

>>> rtl/go_back_n_sender_window.sv
// ----------------------------------------------------------------------------
// go_back_n_sender_window
// Go-back-n sender: pending payload queue, sliding window and resend timer.
//
// command channel: a transaction is taken on a clock edge with start_i high
// and busy_o low; operation_i selects enqueue, send, ack or time tick.
// a two entry command queue sits in front of the execution unit, so new
// commands are taken while earlier ones still run; busy_o rises only when
// that queue is full.
// results: each result is on the result ports for one cycle with
// result_valid_o high, last_o marks the final result of a command. the
// receiver cannot stall, results are never held back.
// path: a status result is registered from the queued command; send and
// timeout commands pass the send or resend state, the registered read of
// the pending queue or window RAM and the result register, and then give
// one frame per cycle. enqueue and ack are handled in the idle state; a
// send or timeout command holds the execution unit until its frames are out.
// config: cfg index 0 is window size, 1 is the timeout; writes are taken
// every cycle and are meant for an idle block.
// reset: sequence numbers, queue pointers and timer are cleared, leaving the window empty.
// ----------------------------------------------------------------------------
module go_back_n_sender_window #(
  parameter int MAX_WINDOW    = 8,
  parameter int SEQ_BITS      = 8,
  parameter int PENDING_DEPTH = 16,
  parameter int PAYLOAD_BITS  = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic [1:0]                         operation_i,
  input  logic [PAYLOAD_BITS-1:0]            payload_i,
  input  logic [SEQ_BITS-1:0]                ack_number_i,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [gbn_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [gbn_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  output logic                               result_valid_o,
  output logic [1:0]                         kind_o,
  output logic [SEQ_BITS-1:0]                seq_number_o,
  output logic [PAYLOAD_BITS-1:0]            frame_payload_o,
  output logic                               last_o,
  output logic [1:0]                         status_o,
  output logic                               finished_o
);
  import gbn_pkg::*;

  cmd_ctrl_t               cmd;
  logic [PAYLOAD_BITS-1:0] cmd_payload;
  logic [SEQ_BITS-1:0]     cmd_ack;
  logic                    pop;
  logic [WIN_CFG_BITS-1:0] window_size_q;
  logic [TMO_CFG_BITS-1:0] timeout_ticks_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_size_q   <= WIN_RESET;
      timeout_ticks_q <= TMO_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_WINDOW_SIZE:   window_size_q   <= cfg_data_i[WIN_CFG_BITS-1:0];
        CFG_TIMEOUT_TICKS: timeout_ticks_q <= cfg_data_i[TMO_CFG_BITS-1:0];
        default:           window_size_q   <= window_size_q;
      endcase
    end
  end

  gbn_front #(
    .PAYLOAD_BITS (PAYLOAD_BITS),
    .SEQ_BITS     (SEQ_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .operation_i   (operation_i),
    .payload_i     (payload_i),
    .ack_number_i  (ack_number_i),
    .busy_o        (busy_o),
    .cmd_o         (cmd),
    .cmd_payload_o (cmd_payload),
    .cmd_ack_o     (cmd_ack),
    .pop_i         (pop)
  );

  gbn_back #(
    .MAX_WINDOW    (MAX_WINDOW),
    .SEQ_BITS      (SEQ_BITS),
    .PENDING_DEPTH (PENDING_DEPTH),
    .PAYLOAD_BITS  (PAYLOAD_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .cmd_payload_i   (cmd_payload),
    .cmd_ack_i       (cmd_ack),
    .pop_o           (pop),
    .window_size_i   (window_size_q),
    .timeout_ticks_i (timeout_ticks_q),
    .result_valid_o  (result_valid_o),
    .kind_o          (kind_o),
    .seq_number_o    (seq_number_o),
    .frame_payload_o (frame_payload_o),
    .last_o          (last_o),
    .status_o        (status_o),
    .finished_o      (finished_o)
  );

  // frames only go out while something is outstanding
  a_frame_not_finished: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (kind_o != KIND_STATUS) |-> !finished_o)
    else $error("frame result flagged as finished");

  // a status result is always the only result of its command
  a_status_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (kind_o == KIND_STATUS) |-> last_o)
    else $error("status result not marked last");

  // frames carry an ok status
  a_frame_status_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (kind_o != KIND_STATUS) |-> (status_o == STAT_OK))
    else $error("frame result with error status");

  // the back end pops only a queued command
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> cmd.valid)
    else $error("command popped from empty queue");

endmodule
